// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VRRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VRRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vrrm_pkg.sv =====
// Shared types and constants of the record ring manager.
package vrrm_pkg;

  localparam int RING_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int RING_SIZE_RST    = 4096;
  localparam int MIN_SIZE         = 16;

  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int FIELD_W = 12;
  localparam int CFG_W   = 13;
  localparam int HDR_W   = 13;

  localparam logic [HDR_W-1:0] WRAP_MARK = 13'h1FFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_RESERVE  = 2'd0,
    CMD_WR_COMPLETE = 2'd1,
    CMD_RD_PEEK     = 2'd2,
    CMD_RD_COMPLETE = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RES_WRAP,
    S_WC_HDR,
    S_RD_HDR,
    S_RD_HDR0
  } state_e;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] elen;
    logic               empty;
  } res_t;

endpackage

// ===== rtl/vrrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vrrm_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vrrm_core.sv =====
// Sequencer and position registers: read-modify-write of the header memory.
module vrrm_core #(
  parameter int RING_BYTES   = vrrm_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = vrrm_pkg::HEADER_BYTES_DEF,
  localparam int PW = $clog2(RING_BYTES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vrrm_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vrrm_pkg::CMD_W-1:0]    cmd_i,
  input  logic [vrrm_pkg::FIELD_W-1:0]  payload_len_i,
  input  logic                          out_free_i,
  output vrrm_pkg::res_t                res_o,
  output logic                          mem_we_o,
  output logic [PW-1:0]                 mem_waddr_o,
  output logic [vrrm_pkg::HDR_W-1:0]    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [PW-1:0]                 mem_raddr_o,
  input  logic [vrrm_pkg::HDR_W-1:0]    mem_rdata_i
);

  localparam int SW = PW + 1;
  localparam int AW = ((SW > vrrm_pkg::HDR_W) ? SW : vrrm_pkg::HDR_W) + 1;
  localparam int RST_SIZE = (RING_BYTES < vrrm_pkg::RING_SIZE_RST) ?
                            RING_BYTES : vrrm_pkg::RING_SIZE_RST;
  localparam logic [AW-1:0] HB_A = AW'(HEADER_BYTES);
  localparam logic [vrrm_pkg::HDR_W-1:0] HB_H = vrrm_pkg::HDR_W'(HEADER_BYTES);
  localparam logic [AW-1:0] MIN_A = AW'(vrrm_pkg::MIN_SIZE);
  localparam logic [AW-1:0] MAX_A = AW'(RING_BYTES);

  vrrm_pkg::state_e            state_q, state_d;
  vrrm_pkg::cmd_e              cmd_q;
  logic [vrrm_pkg::HDR_W-1:0]  len_q;
  logic [PW-1:0]               w_q, w_d, r_q, r_d;
  logic                        pend_q, pend_d;
  logic [SW-1:0]               size_q, size_d;

  logic                        accept;
  logic [AW-1:0]               size_a, w_a, r_a, hdr_a, lim_a, cfg_a, sat_a;
  logic                        wrap, wrap_busy, mark_fits, res_ok;
  logic [AW-1:0]               free_a, adv_w, adv_r;
  logic                        r_high, align_fail, align_empty;
  logic [PW-1:0]               r1, w_next, r_next;
  logic                        is_mark;
  logic [vrrm_pkg::HDR_W-1:0]  elen_h;
  vrrm_pkg::status_e           fail_st;

  assign accept     = in_valid_i && (state_q == vrrm_pkg::S_IDLE);
  assign in_stall_o = (state_q != vrrm_pkg::S_IDLE);

  // Shared decisions
  always_comb begin
    size_a = AW'(size_q);
    w_a    = AW'(w_q);
    r_a    = AW'(r_q);
    hdr_a  = AW'(mem_rdata_i);
    lim_a  = size_a - HB_A;

    wrap      = (w_a + AW'(len_q)) >= size_a;
    wrap_busy = wrap && ((r_q > w_q) || (r_q == '0));
    mark_fits = w_a <= lim_a;
    free_a    = (w_q < r_q) ? (r_a - w_a - AW'(1)) : (size_a - w_a - AW'(1));
    res_ok    = free_a >= AW'(len_q);

    r_high      = r_a > lim_a;
    align_fail  = r_high && !(w_q < r_q);
    r1          = r_high ? '0 : r_q;
    align_empty = align_fail || (w_q == r1);

    is_mark = (mem_rdata_i == vrrm_pkg::WRAP_MARK);
    adv_w   = w_a + hdr_a;
    adv_r   = r_a + hdr_a;
    w_next  = (adv_w >= size_a) ? '0 : adv_w[PW-1:0];
    r_next  = (adv_r >= size_a) ? '0 : adv_r[PW-1:0];
    elen_h  = (mem_rdata_i >= HB_H) ? (mem_rdata_i - HB_H) : '0;
    fail_st = (cmd_q == vrrm_pkg::CMD_RD_PEEK) ? vrrm_pkg::ST_EMPTY : vrrm_pkg::ST_INVALID;

    cfg_a = AW'(cfg_wdata_i);
    if (cfg_a < MIN_A) begin
      sat_a = MIN_A;
    end else if (cfg_a > MAX_A) begin
      sat_a = MAX_A;
    end else begin
      sat_a = cfg_a;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vrrm_pkg::S_IDLE: begin
        if (accept) state_d = vrrm_pkg::S_EXEC;
      end
      vrrm_pkg::S_EXEC: begin
        case (cmd_q)
          vrrm_pkg::CMD_WR_RESERVE: begin
            if (wrap && !wrap_busy) state_d = vrrm_pkg::S_RES_WRAP;
            else if (out_free_i)    state_d = vrrm_pkg::S_IDLE;
          end
          vrrm_pkg::CMD_WR_COMPLETE: begin
            if (pend_q)          state_d = vrrm_pkg::S_WC_HDR;
            else if (out_free_i) state_d = vrrm_pkg::S_IDLE;
          end
          default: begin
            if (!align_empty)    state_d = vrrm_pkg::S_RD_HDR;
            else if (out_free_i) state_d = vrrm_pkg::S_IDLE;
          end
        endcase
      end
      vrrm_pkg::S_RD_HDR: begin
        if (is_mark && (w_q != '0)) state_d = vrrm_pkg::S_RD_HDR0;
        else if (out_free_i)        state_d = vrrm_pkg::S_IDLE;
      end
      vrrm_pkg::S_RES_WRAP,
      vrrm_pkg::S_WC_HDR,
      vrrm_pkg::S_RD_HDR0: begin
        if (out_free_i) state_d = vrrm_pkg::S_IDLE;
      end
      default: state_d = vrrm_pkg::S_IDLE;
    endcase
  end

  // Outputs, memory controls and position updates
  always_comb begin
    w_d         = w_q;
    r_d         = r_q;
    pend_d      = pend_q;
    size_d      = size_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = w_q;
    mem_wdata_o = len_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = r1;
    res_o       = '0;
    res_o.status = vrrm_pkg::ST_OK;

    case (state_q)
      vrrm_pkg::S_EXEC: begin
        case (cmd_q)
          vrrm_pkg::CMD_WR_RESERVE: begin
            pend_d = 1'b0;
            if (wrap && !wrap_busy) begin
              // marker at the old position if it fits, record restarts at offset 0
              mem_we_o    = mark_fits;
              mem_wdata_o = vrrm_pkg::WRAP_MARK;
              w_d         = '0;
            end else if (out_free_i) begin
              res_o.valid = 1'b1;
              if (wrap || !res_ok) begin
                res_o.status = vrrm_pkg::ST_BUSY;
              end else begin
                mem_we_o     = 1'b1;
                pend_d       = 1'b1;
                res_o.offset = vrrm_pkg::FIELD_W'(w_a + HB_A);
              end
            end else begin
              pend_d = pend_q;
            end
          end
          vrrm_pkg::CMD_WR_COMPLETE: begin
            if (pend_q) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = w_q;
            end else if (out_free_i) begin
              res_o.valid  = 1'b1;
              res_o.status = vrrm_pkg::ST_INVALID;
            end
          end
          default: begin
            if (!align_empty) begin
              r_d         = r1;
              mem_re_o    = 1'b1;
              mem_raddr_o = r1;
            end else if (out_free_i) begin
              r_d          = align_fail ? r_q : r1;
              res_o.valid  = 1'b1;
              res_o.status = fail_st;
            end
          end
        endcase
      end
      vrrm_pkg::S_RES_WRAP: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          if (!res_ok) begin
            res_o.status = vrrm_pkg::ST_BUSY;
          end else begin
            mem_we_o     = 1'b1;
            pend_d       = 1'b1;
            res_o.offset = vrrm_pkg::FIELD_W'(w_a + HB_A);
          end
        end
      end
      vrrm_pkg::S_WC_HDR: begin
        if (out_free_i) begin
          w_d         = w_next;
          pend_d      = 1'b0;
          res_o.valid = 1'b1;
        end
      end
      vrrm_pkg::S_RD_HDR: begin
        if (is_mark) begin
          if (w_q != '0) begin
            r_d         = '0;
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
          end else if (out_free_i) begin
            r_d          = '0;
            res_o.valid  = 1'b1;
            res_o.status = fail_st;
          end
        end else if (out_free_i) begin
          res_o.valid = 1'b1;
          if (cmd_q == vrrm_pkg::CMD_RD_PEEK) begin
            res_o.offset = vrrm_pkg::FIELD_W'(r_a + HB_A);
            res_o.elen   = vrrm_pkg::FIELD_W'(elen_h);
          end else begin
            r_d = r_next;
          end
        end
      end
      vrrm_pkg::S_RD_HDR0: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          if (cmd_q == vrrm_pkg::CMD_RD_PEEK) begin
            res_o.offset = vrrm_pkg::FIELD_W'(r_a + HB_A);
            res_o.elen   = vrrm_pkg::FIELD_W'(elen_h);
          end else begin
            r_d = r_next;
          end
        end
      end
      default: begin
      end
    endcase

    res_o.empty = (r_d == w_d);

    // size write empties the ring
    if (cfg_we_i) begin
      size_d = sat_a[SW-1:0];
      w_d    = '0;
      r_d    = '0;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vrrm_pkg::S_IDLE;
      w_q     <= '0;
      r_q     <= '0;
      pend_q  <= 1'b0;
      size_q  <= SW'(RST_SIZE);
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      r_q     <= r_d;
      pend_q  <= pend_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= vrrm_pkg::cmd_e'(cmd_i);
      len_q <= vrrm_pkg::HDR_W'(payload_len_i) + HB_H;
    end
  end

endmodule

// ===== rtl/variable_record_ring_manager_top.sv =====
// Top level of the variable-length record ring manager.
// Usage:
//   Request channel: in_valid_i / in_stall_o with cmd_i and payload_len_i.
//   A request is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Result channel: out_valid_o / out_stall_i with status_o, data_offset_o,
//   entry_len_o and ring_is_empty_o; one result per request, in order.
//   The result is loaded into the output register from S_EXEC, or from a later
//   state for a write complete that commits or a reserve that wraps (S_WC_HDR,
//   S_RES_WRAP) and for a read that finds the ring not empty (S_RD_HDR, then
//   S_RD_HDR0 when a wrap marker is skipped). Each extra state is one header
//   memory access: a registered read or the marker write. A new request is
//   taken the cycle after the result is loaded.
//   While the receiver stalls, the result holds; the next request is still
//   taken and worked up to its result, which then waits for the register.
//   cfg_we_i writes the ring size and empties the ring; write only when idle.
//   Reset: positions zero, nothing pending, ring size 4096 (capped to the
//   ring). The header memory needs no clearing; unwritten entries are
//   never read by legal use.
`include "assert_macros.svh"

module variable_record_ring_manager_top #(
  parameter int RING_BYTES   = vrrm_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = vrrm_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vrrm_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vrrm_pkg::CMD_W-1:0]    cmd_i,
  input  logic [vrrm_pkg::FIELD_W-1:0]  payload_len_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vrrm_pkg::ST_W-1:0]     status_o,
  output logic [vrrm_pkg::FIELD_W-1:0]  data_offset_o,
  output logic [vrrm_pkg::FIELD_W-1:0]  entry_len_o,
  output logic                          ring_is_empty_o
);

  localparam int PW = $clog2(RING_BYTES);

  vrrm_pkg::res_t              res;
  logic                        out_free;
  logic                        mem_we, mem_re;
  logic [PW-1:0]               mem_waddr, mem_raddr;
  logic [vrrm_pkg::HDR_W-1:0]  mem_wdata, mem_rdata;

  // output register
  logic                        out_valid_q;
  vrrm_pkg::status_e           status_q;
  logic [vrrm_pkg::FIELD_W-1:0] offset_q, elen_q;
  logic                        empty_q;

  // register free now or emptied at this edge
  assign out_free = !out_valid_q || !out_stall_i;

  vrrm_core #(
    .RING_BYTES  (RING_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .payload_len_i(payload_len_i),
    .out_free_i   (out_free),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // one header word per ring byte position
  vrrm_ram #(
    .WIDTH(vrrm_pkg::HDR_W),
    .DEPTH(RING_BYTES)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      offset_q <= res.offset;
      elen_q   <= res.elen;
      empty_q  <= res.empty;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign data_offset_o   = offset_q;
  assign entry_len_o     = elen_q;
  assign ring_is_empty_o = empty_q;

  // a result never overwrites one still waiting
  `VRRM_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, res.valid, out_free, "result overwrote a pending one")
  // a loaded result shows on the port next cycle
  `VRRM_ASSERT_NEXT(a_res_shown, clk_i, rst_ni, res.valid, out_valid_o, "result not presented")
  // an accepted request blocks the next until its result is loaded
  `VRRM_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

endmodule
